/* rtl/mf3_pkg.sv */
// Package for the 3x3 median filter: pixel and window types, register map,
// reset values and the control struct passed to the median stage.
// No dependencies.
package mf3_pkg;

	localparam int PIX_W        = 8;
	localparam int WIN_SIDE     = 3;
	localparam int WIN_N        = WIN_SIDE * WIN_SIDE;
	localparam int WIN_CENTRE   = 4;
	localparam int MEDIAN_RANK  = 4;
	localparam int RANK_W       = $clog2(WIN_N + 1);

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int IMG_WIDTH_W   = 11;
	localparam int IMG_HEIGHT_W  = 16;
	localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = IMG_WIDTH_W'(640);
	localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = IMG_HEIGHT_W'(480);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_WIDTH_IDX  = 1'b0;
	localparam logic REG_HEIGHT_IDX = 1'b1;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic interior;
		logic frame_end;
	} mf3_ctl_t;

endpackage

/* rtl/median_filter_3x3.sv */
// 3x3 median filter over a raster-order stream of 8-bit pixels. One item is
// taken per clock while pix_ready is high; res_ready back-pressure stalls it.
// Each pixel item shifts the 3x3 window; a result for a pixel appears once
// image_width+1 further items have entered the window (flush items at frame
// start serve as filler) and it has passed the pipeline registers in order:
// line RAM read, window shift, compare stage, rank select into the output
// register. The single line RAM is read and written once per item. Border
// pixels, and all pixels when the width or height is below 3, pass through.
// The line RAM holds MAX_WIDTH entries of upper-row value plus middle-row
// value and tag, is not cleared after reset, and the block is ready from the
// first clock. Registers: image_width at 0x0, image_height at 0x4.
module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic               action,
	input  logic [PIX_W-1:0]   pixel_value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [PIX_W-1:0]   filtered_pixel,
	output logic               frame_end
);

	localparam int ADDR_W  = $clog2(MAX_WIDTH);
	localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
	localparam int MID_W   = PIX_W + 1;
	localparam int RAM_W   = PIX_W + MID_W;

	// configuration
	logic [IMG_WIDTH_W-1:0]  image_width_q;
	logic [IMG_HEIGHT_W-1:0] image_height_q;
	logic [CNT_W-1:0]        w_eff;
	logic [IMG_HEIGHT_W-1:0] h_eff;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_WIDTH_IDX:  image_width_q  <= pwdata[IMG_WIDTH_W-1:0];
				REG_HEIGHT_IDX: image_height_q <= pwdata[IMG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH_IDX:  prdata = PDATA_W'(image_width_q);
			REG_HEIGHT_IDX: prdata = PDATA_W'(image_height_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end else begin
			w_eff = CNT_W'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? IMG_HEIGHT_W'(1) : image_height_q;
	end

	// pipeline flow control
	logic v1_s1, v2_s2, v3_s3, res_valid_q;
	logic out_free, s3_free, s2_free;
	logic s1_go, s2_go, s3_go, in_fire;

	assign out_free  = !res_valid_q || res_ready;
	assign s3_go     = v3_s3 && out_free;
	assign s3_free   = !v3_s3 || out_free;
	assign s2_go     = v2_s2 && s3_free;
	assign s2_free   = !v2_s2 || s3_free;
	assign s1_go     = v1_s1 && s2_free;
	assign pix_ready = !v1_s1 || s2_free;
	assign in_fire   = pix_valid && pix_ready;

	// input side: position, line pointer, RAM read
	logic [IMG_HEIGHT_W-1:0] in_row_q;
	logic [ADDR_W-1:0]       in_col_q;
	logic [ADDR_W-1:0]       ptr_q, rd_addr, ptr_next;
	logic                    enter;

	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [RAM_W-1:0]     wr_data, rd_data;

	logic                 tag_s1, hit_s1;
	pix_t                 pix_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [RAM_W-1:0]     fwd_s1;

	assign enter   = (action == ACT_PIXEL) || (in_row_q == '0 && in_col_q == '0);
	assign rd_addr = (CNT_W'(ptr_q) >= w_eff) ? '0 : ptr_q;
	assign ptr_next = (CNT_W'(rd_addr) + CNT_W'(1) >= w_eff) ? '0 : rd_addr + ADDR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			ptr_q    <= '0;
			v1_s1    <= 1'b0;
		end else begin
			if (in_fire && enter) begin
				ptr_q <= ptr_next;
				v1_s1 <= 1'b1;
			end else if (s1_go) begin
				v1_s1 <= 1'b0;
			end
			if (in_fire && action == ACT_PIXEL) begin
				if (CNT_W'(in_col_q) >= w_eff - CNT_W'(1)) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q >= h_eff - IMG_HEIGHT_W'(1)) ? '0
						: in_row_q + IMG_HEIGHT_W'(1);
				end else begin
					in_col_q <= in_col_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && enter) begin
			tag_s1  <= (action == ACT_PIXEL);
			pix_s1  <= (action == ACT_PIXEL) ? pixel_value : '0;
			addr_s1 <= rd_addr;
			// the RAM returns pre-write data when this cycle writes the same entry
			hit_s1  <= wr_en && (wr_addr == rd_addr);
			fwd_s1  <= wr_data;
		end
	end

	mf3_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (in_fire && enter),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// window shift and output position
	logic [CNT_W-1:0]        fill_q;
	logic [RAM_W-1:0]        line_word;
	logic [MID_W-1:0]        mid_word;
	logic                    mid_tag;
	pix_t                    win_q [WIN_N];
	pix_t                    win_nxt [WIN_N];
	logic                    centre_tag_q, right_tag_q;
	logic [IMG_HEIGHT_W-1:0] out_row_q;
	logic [ADDR_W-1:0]       out_col_q;
	logic                    interior, col_last, row_last;

	pix_t     win_s2 [WIN_N];
	mf3_ctl_t ctl_s2;
	mf3_ctl_t ctl_s3;
	pix_t     med_result;

	assign line_word = hit_s1 ? fwd_s1 : rd_data;
	assign mid_word  = line_word[RAM_W-1:PIX_W];
	// the line fills as a prefix from entry zero, so a count marks what is valid
	assign mid_tag   = mid_word[PIX_W] && (hit_s1 || CNT_W'(addr_s1) < fill_q);

	assign wr_en   = s1_go;
	assign wr_addr = addr_s1;
	assign wr_data = {tag_s1, pix_s1, mid_word[PIX_W-1:0]};

	always_comb begin
		for (int r = 0; r < WIN_SIDE; r++) begin
			win_nxt[r*WIN_SIDE]     = win_q[r*WIN_SIDE + 1];
			win_nxt[r*WIN_SIDE + 1] = win_q[r*WIN_SIDE + 2];
		end
		win_nxt[WIN_SIDE - 1]     = line_word[PIX_W-1:0];
		win_nxt[2*WIN_SIDE - 1]   = mid_word[PIX_W-1:0];
		win_nxt[WIN_N - 1]        = pix_s1;
	end

	assign col_last = CNT_W'(out_col_q) >= w_eff - CNT_W'(1);
	assign row_last = out_row_q >= h_eff - IMG_HEIGHT_W'(1);
	assign interior = w_eff >= CNT_W'(WIN_SIDE) && h_eff >= IMG_HEIGHT_W'(WIN_SIDE)
		&& out_row_q != '0 && out_row_q <= h_eff - IMG_HEIGHT_W'(2)
		&& out_col_q != '0 && CNT_W'(out_col_q) <= w_eff - CNT_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			centre_tag_q <= 1'b0;
			right_tag_q  <= 1'b0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			v2_s2        <= 1'b0;
			for (int i = 0; i < WIN_N; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (s1_go) begin
				if (CNT_W'(addr_s1) >= fill_q) begin
					fill_q <= CNT_W'(addr_s1) + CNT_W'(1);
				end
				win_q        <= win_nxt;
				centre_tag_q <= right_tag_q;
				right_tag_q  <= mid_tag;
				v2_s2        <= right_tag_q;
				// advance the output position only for a real centre pixel
				if (right_tag_q) begin
					if (col_last) begin
						out_col_q <= '0;
						out_row_q <= row_last ? '0 : out_row_q + IMG_HEIGHT_W'(1);
					end else begin
						out_col_q <= out_col_q + ADDR_W'(1);
					end
				end
			end else if (s2_go) begin
				v2_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_s2             <= win_nxt;
			ctl_s2.interior    <= interior;
			ctl_s2.frame_end   <= col_last && row_last;
		end
	end

	mf3_median u_median (
		.clk    (clk),
		.load   (s2_go),
		.win    (win_s2),
		.ctl    (ctl_s2),
		.result (med_result),
		.ctl_s3 (ctl_s3)
	);

	// output register
	pix_t res_pix_q;
	logic res_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s2_go) begin
				v3_s3 <= 1'b1;
			end else if (s3_go) begin
				v3_s3 <= 1'b0;
			end
			if (s3_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			res_pix_q <= med_result;
			res_end_q <= ctl_s3.frame_end;
		end
	end

	assign res_valid      = res_valid_q;
	assign filtered_pixel = res_pix_q;
	assign frame_end      = res_end_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_WIDTH))
		else $error("line fill count beyond line RAM depth");

	a_fwd_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && hit_s1) |-> (w_eff == CNT_W'(1)))
		else $error("line RAM forward taken with width above one");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && right_tag_q && col_last && row_last)
		|=> (out_row_q == '0 && out_col_q == '0))
		else $error("output position did not wrap at frame end");

	a_centre_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && right_tag_q) |=> centre_tag_q)
		else $error("centre tag lost in window shift");

endmodule

/* rtl/mf3_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, read-first on a same-address collision. No dependencies.
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mf3_median.sv */
// Median-of-nine selection: one registered stage of pairwise compares,
// then rank counting and selection. Depends on mf3_pkg.
module mf3_median import mf3_pkg::*; (
	input  logic     clk,
	input  logic     load,
	input  pix_t     win [WIN_N],
	input  mf3_ctl_t ctl,
	output pix_t     result,
	output mf3_ctl_t ctl_s3
);

	// lt_s3[i][j]: value j is strictly below value i
	logic [WIN_N-1:0] lt_s3 [WIN_N];
	pix_t             val_s3 [WIN_N];
	pix_t             med;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < WIN_N; i++) begin
				val_s3[i] <= win[i];
				for (int j = 0; j < WIN_N; j++) begin
					lt_s3[i][j] <= (win[j] < win[i]);
				end
			end
			ctl_s3 <= ctl;
		end
	end

	always_comb begin
		logic [RANK_W-1:0] below;
		logic [RANK_W-1:0] at_or_below;
		med = val_s3[WIN_CENTRE];
		// scan from the top so the lowest matching index wins
		for (int i = WIN_N - 1; i >= 0; i--) begin
			below       = '0;
			at_or_below = '0;
			for (int j = 0; j < WIN_N; j++) begin
				below       = below + RANK_W'(lt_s3[i][j]);
				at_or_below = at_or_below + RANK_W'(!lt_s3[j][i]);
			end
			if (below <= RANK_W'(MEDIAN_RANK) && at_or_below >= RANK_W'(MEDIAN_RANK + 1)) begin
				med = val_s3[i];
			end
		end
	end

	assign result = ctl_s3.interior ? med : val_s3[WIN_CENTRE];

endmodule
